### rtl/aqc_pkg.sv
// ============================================================================
// aqc_pkg
// Shared types, codes and constants for the accelerated quadrature counter.
// ============================================================================
`default_nettype none

package aqc_pkg;

    // Request operation codes. The remaining code is unused and changes nothing.
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_LOAD   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    // Register indexes on the configuration port (byte address is 4 * index).
    localparam int unsigned CfgAddrW = 5;
    localparam logic [2:0] REG_MIN_LIMIT      = 3'd0;
    localparam logic [2:0] REG_MAX_LIMIT      = 3'd1;
    localparam logic [2:0] REG_FAST_STEP      = 3'd2;
    localparam logic [2:0] REG_SLOW_STEP      = 3'd3;
    localparam logic [2:0] REG_FAST_WINDOW_MS = 3'd4;

    // Register values after reset.
    localparam logic signed [31:0] RST_MIN_LIMIT      = 32'sd0;
    localparam logic signed [31:0] RST_MAX_LIMIT      = 32'sd100;
    localparam logic [15:0]        RST_FAST_STEP      = 16'd10;
    localparam logic [15:0]        RST_SLOW_STEP      = 16'd1;
    localparam logic [31:0]        RST_FAST_WINDOW_MS = 32'd50;

    // Direction of travel, indexed by {previous AB, current AB}.
    localparam logic signed [1:0] DIR_TABLE [16] = '{
         2'sd0,  2'sd1, -2'sd1,  2'sd0,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
         2'sd0, -2'sd1,  2'sd1,  2'sd0
    };

    // Configuration register set.
    typedef struct packed {
        logic signed [31:0] min_limit;
        logic signed [31:0] max_limit;
        logic [15:0]        fast_step;
        logic [15:0]        slow_step;
        logic [31:0]        fast_window_ms;
    } t_cfg;

    // Decoder state carried from one request to the next.
    typedef struct packed {
        logic [1:0]         prev_ab;
        logic               change_parity;
        logic [31:0]        last_step_ms;
        logic signed [31:0] position;
    } t_state;

endpackage

`default_nettype wire

### rtl/aqc_if.sv
// ============================================================================
// aqc_in_if / aqc_out_if
// Valid/ready channels for requests into and results out of the counter.
// ============================================================================
`default_nettype none

interface aqc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic               a_level;
    logic               b_level;
    logic [31:0]        now_ms;
    logic signed [31:0] load_value;

    modport source (output valid, operation, a_level, b_level, now_ms, load_value,
                    input ready);
    modport sink   (input valid, operation, a_level, b_level, now_ms, load_value,
                    output ready);
endinterface

interface aqc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [1:0]  moved;

    modport source (output valid, position, moved, input ready);
    modport sink   (input valid, position, moved, output ready);
endinterface

`default_nettype wire

### rtl/accelerated_quadrature_counter.sv
// ============================================================================
// accelerated_quadrature_counter
// Quadrature decoder with a clamped, speed-dependent position count.
// ============================================================================
// The block takes one request per clock while results are taken and
// returns one result per request. A request is captured in an input
// register; once the result register is free, the step logic updates the
// decoder state and writes the result register. Requests flow back to back
// at one per cycle as long as results are taken; the result register holds
// while the output is stalled, and the input register still takes one more
// request behind it. Configuration registers are written over the APB port
// and should change only while no request is in flight.
`default_nettype none

module accelerated_quadrature_counter (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    aqc_in_if.sink                            i_in,
    aqc_out_if.source                         o_out,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [aqc_pkg::CfgAddrW-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);
    import aqc_pkg::*;

    t_cfg               w_cfg;
    t_state             r_state;
    t_state             n_state;
    logic signed [1:0]  n_moved;

    logic               r_in_valid;
    logic [1:0]         r_operation;
    logic               r_a_level;
    logic               r_b_level;
    logic [31:0]        r_now_ms;
    logic signed [31:0] r_load_value;

    logic               r_out_valid;
    logic signed [31:0] r_position;
    logic signed [1:0]  r_moved;

    logic               w_advance;
    logic               w_accept;

    aqc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    aqc_step u_step (
        .i_cfg        (w_cfg),
        .i_state      (r_state),
        .i_operation  (r_operation),
        .i_a_level    (r_a_level),
        .i_b_level    (r_b_level),
        .i_now_ms     (r_now_ms),
        .i_load_value (r_load_value),
        .o_state      (n_state),
        .o_moved      (n_moved)
    );

    // Handshake: the held request moves on when the result register is free.
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;
    assign w_accept   = i_in.valid && i_in.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_operation  <= i_in.operation;
            r_a_level    <= i_in.a_level;
            r_b_level    <= i_in.b_level;
            r_now_ms     <= i_in.now_ms;
            r_load_value <= i_in.load_value;
        end
    end

    // Decoder state, updated as each request is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_position <= n_state.position;
            r_moved    <= n_moved;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.position = r_position;
    assign o_out.moved    = r_moved;

endmodule

`default_nettype wire

### rtl/aqc_apb_regs.sv
// ============================================================================
// aqc_apb_regs
// APB-style register file holding limits, step sizes and the fast window.
// ============================================================================
`default_nettype none

module aqc_apb_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [aqc_pkg::CfgAddrW-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output aqc_pkg::t_cfg                     o_cfg
);
    import aqc_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[CfgAddrW-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_limit      <= RST_MIN_LIMIT;
            r_cfg.max_limit      <= RST_MAX_LIMIT;
            r_cfg.fast_step      <= RST_FAST_STEP;
            r_cfg.slow_step      <= RST_SLOW_STEP;
            r_cfg.fast_window_ms <= RST_FAST_WINDOW_MS;
        end else if (w_wr) begin
            case (w_idx)
                REG_MIN_LIMIT:      r_cfg.min_limit      <= $signed(pwdata);
                REG_MAX_LIMIT:      r_cfg.max_limit      <= $signed(pwdata);
                REG_FAST_STEP:      r_cfg.fast_step      <= pwdata[15:0];
                REG_SLOW_STEP:      r_cfg.slow_step      <= pwdata[15:0];
                REG_FAST_WINDOW_MS: r_cfg.fast_window_ms <= pwdata;
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (w_idx)
            REG_MIN_LIMIT:      prdata = r_cfg.min_limit;
            REG_MAX_LIMIT:      prdata = r_cfg.max_limit;
            REG_FAST_STEP:      prdata = {16'd0, r_cfg.fast_step};
            REG_SLOW_STEP:      prdata = {16'd0, r_cfg.slow_step};
            REG_FAST_WINDOW_MS: prdata = r_cfg.fast_window_ms;
            default:            prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/aqc_step.sv
// ============================================================================
// aqc_step
// Next-state and result logic for one request: decode, step, clamp, load, clear.
// ============================================================================
`default_nettype none

module aqc_step (
    input  wire aqc_pkg::t_cfg            i_cfg,
    input  wire aqc_pkg::t_state          i_state,
    input  wire logic [1:0]               i_operation,
    input  wire logic                     i_a_level,
    input  wire logic                     i_b_level,
    input  wire logic [31:0]              i_now_ms,
    input  wire logic signed [31:0]       i_load_value,
    output aqc_pkg::t_state               o_state,
    output logic signed [1:0]             o_moved
);
    import aqc_pkg::*;

    logic [1:0]         w_cur;
    logic               w_changed;
    logic signed [1:0]  w_dir;
    logic               w_parity;
    logic               w_step;
    logic [31:0]        w_since;
    logic               w_fast;
    logic [15:0]        w_inc;
    logic signed [33:0] w_pos_x;
    logic signed [33:0] w_inc_x;
    logic signed [33:0] w_sum;
    logic signed [33:0] w_hi_clamp;
    logic signed [31:0] w_clamped;
    logic               w_load_ok;

    // Transition decode and parity of pin changes.
    assign w_cur     = {i_a_level, i_b_level};
    assign w_changed = (w_cur != i_state.prev_ab);
    assign w_dir     = DIR_TABLE[{i_state.prev_ab, w_cur}];
    assign w_parity  = i_state.change_parity ^ w_changed;
    assign w_step    = (i_operation == OP_SAMPLE) && w_changed
                       && (w_dir != 2'sd0) && !w_parity;

    // Fast or slow increment from the time since the last step.
    assign w_since = (i_state.last_step_ms != 32'd0) ? (i_now_ms - i_state.last_step_ms)
                                                      : 32'd0;
    assign w_fast  = (w_since != 32'd0) && (w_since < i_cfg.fast_window_ms);
    assign w_inc   = w_fast ? i_cfg.fast_step : i_cfg.slow_step;

    // Wide add, then clamp to the upper and then the lower limit.
    assign w_pos_x = {{2{i_state.position[31]}}, i_state.position};
    assign w_inc_x = $signed({18'd0, w_inc});
    assign w_sum   = (w_dir == 2'sd1) ? (w_pos_x + w_inc_x) : (w_pos_x - w_inc_x);

    always_comb begin
        if (w_sum > $signed({{2{i_cfg.max_limit[31]}}, i_cfg.max_limit})) begin
            w_hi_clamp = $signed({{2{i_cfg.max_limit[31]}}, i_cfg.max_limit});
        end else begin
            w_hi_clamp = w_sum;
        end
        if (w_hi_clamp < $signed({{2{i_cfg.min_limit[31]}}, i_cfg.min_limit})) begin
            w_clamped = i_cfg.min_limit;
        end else begin
            w_clamped = w_hi_clamp[31:0];
        end
    end

    assign w_load_ok = (i_load_value >= i_cfg.min_limit) && (i_load_value <= i_cfg.max_limit);

    // Per-operation state update.
    always_comb begin
        o_state = i_state;
        o_moved = 2'sd0;
        case (i_operation)
            OP_SAMPLE: begin
                o_state.prev_ab       = w_cur;
                o_state.change_parity = w_parity;
                if (w_step) begin
                    o_state.position     = w_clamped;
                    o_state.last_step_ms = i_now_ms;
                    o_moved              = w_dir;
                end
            end
            OP_LOAD: begin
                if (w_load_ok) begin
                    o_state.position = i_load_value;
                end
            end
            OP_CLEAR: begin
                o_state.position     = 32'sd0;
                o_state.last_step_ms = i_now_ms;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### sim/accelerated_quadrature_counter_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// accelerated_quadrature_counter_tb
// Self-checking bench for the quadrature counter. A short table of directed
// requests covers the pin transitions, the limits, loads, clears and the
// unused operation. Random requests follow, mostly well-formed rotation with
// random timing, under several register settings and three idling phases.
// Every result is checked against a typed-in row or the in-bench count model.
// ============================================================================

module accelerated_quadrature_counter_tb;
    import aqc_pkg::*;

    localparam logic [1:0]  OpUnused        = 2'd3;
    localparam int unsigned StallLimit      = 2000;
    localparam int unsigned DrainCycles     = 8;
    localparam int unsigned ItemsPerSetting = 125;

    // Direction of travel indexed by {previous AB, current AB}.
    localparam logic signed [1:0] StepTable [16] = '{
         2'sd0,  2'sd1, -2'sd1,  2'sd0,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
         2'sd0, -2'sd1,  2'sd1,  2'sd0
    };

    typedef struct packed {
        logic [1:0]         op;
        logic               a;
        logic               b;
        logic [31:0]        now;
        logic signed [31:0] load;
    } t_req;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [1:0]  moved;
    } t_res;

    typedef struct {
        t_req req;
        logic typed;
        t_res want;
    } t_row;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CfgAddrW-1:0] paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    aqc_in_if  req_ch ();
    aqc_out_if res_ch ();

    accelerated_quadrature_counter u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch.sink),
        .o_out   (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Model copy of the registers.
    int          lim_lo;
    int          lim_hi;
    logic [15:0] inc_fast;
    logic [15:0] inc_slow;
    logic [31:0] window_ms;

    // Model copy of the decoder state.
    logic [1:0]  last_ab;
    logic        half_cycle;
    logic [31:0] step_stamp;
    int          count;

    t_res        pending_results [$];
    int unsigned err_count = 0;
    int unsigned stall_cycles = 0;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // A typed-in expectation travels alongside the request it belongs to.
    logic row_typed;
    t_res row_want;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic t_row vector_row(input logic [1:0] op, input logic a, input logic b,
                                        input logic [31:0] now, input logic signed [31:0] load,
                                        input logic typed = 1'b0, input int pos = 0,
                                        input logic signed [1:0] mv = 2'sd0);
        t_row row;
        row.req.op        = op;
        row.req.a         = a;
        row.req.b         = b;
        row.req.now       = now;
        row.req.load      = load;
        row.typed         = typed;
        row.want.position = pos;
        row.want.moved    = mv;
        return row;
    endfunction

    // Advances the model by one request and returns the result it causes.
    function automatic t_res count_step(input t_req r);
        logic [1:0]        ab;
        logic signed [1:0] dir;
        logic [31:0]       elapsed;
        longint            nxt;
        t_res              res;
        ab        = {r.a, r.b};
        res.moved = 2'sd0;
        case (r.op)
            OP_SAMPLE: begin
                if (ab != last_ab) begin
                    dir        = StepTable[{last_ab, ab}];
                    half_cycle = ~half_cycle;
                    // Each pin edge flips half_cycle; only an edge that clears it moves the count.
                    if (dir != 2'sd0 && !half_cycle) begin
                        elapsed = (step_stamp != 32'd0) ? r.now - step_stamp : 32'd0;
                        nxt     = longint'(count);
                        if (elapsed != 32'd0 && elapsed < window_ms)
                            nxt += longint'(dir) * longint'(inc_fast);
                        else
                            nxt += longint'(dir) * longint'(inc_slow);
                        // The lower limit wins when the limits are crossed.
                        if (nxt > longint'(lim_hi)) nxt = longint'(lim_hi);
                        if (nxt < longint'(lim_lo)) nxt = longint'(lim_lo);
                        count      = int'(nxt);
                        step_stamp = r.now;
                        res.moved  = dir;
                    end
                    last_ab = ab;
                end
            end
            OP_LOAD: begin
                if (int'(r.load) >= lim_lo && int'(r.load) <= lim_hi)
                    count = int'(r.load);
            end
            OP_CLEAR: begin
                count      = 0;
                step_stamp = r.now;
            end
            default: ;
        endcase
        res.position = count;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // Offers one request after a random gap and holds it until it is taken.
    task automatic send_req(input t_req r, input logic typed, input t_res want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= r.op;
        req_ch.a_level    <= r.a;
        req_ch.b_level    <= r.b;
        req_ch.now_ms     <= r.now;
        req_ch.load_value <= r.load;
        row_typed         <= typed;
        row_want          <= want;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // One register write; psel stays high so writes can run back to back.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_MIN_LIMIT:      lim_lo    = int'(value);
            REG_MAX_LIMIT:      lim_hi    = int'(value);
            REG_FAST_STEP:      inc_fast  = value[15:0];
            REG_SLOW_STEP:      inc_slow  = value[15:0];
            REG_FAST_WINDOW_MS: window_ms = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input int lo, input int hi, input logic [15:0] fast,
                              input logic [15:0] slow, input logic [31:0] win);
        wait_drained();
        write_reg(REG_MIN_LIMIT, lo);
        write_reg(REG_MAX_LIMIT, hi);
        write_reg(REG_FAST_STEP, {16'd0, fast});
        write_reg(REG_SLOW_STEP, {16'd0, slow});
        write_reg(REG_FAST_WINDOW_MS, win);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Receiver: random back-pressure on the result channel.
    always @(posedge clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: results are checked first, then the accepted request is predicted.
    always @(posedge clk) begin
        t_req seen;
        t_res want;
        t_res got;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got.position = res_ch.position;
            got.moved    = res_ch.moved;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", got.position, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.position !== want.position)
                    report_mismatch("position", got.position, want.position);
                if (got.moved !== want.moved)
                    report_mismatch("moved", got.moved, want.moved);
            end
        end
        if (rst_n && req_ch.valid && req_ch.ready) begin
            seen.op   = req_ch.operation;
            seen.a    = req_ch.a_level;
            seen.b    = req_ch.b_level;
            seen.now  = req_ch.now_ms;
            seen.load = req_ch.load_value;
            want      = count_step(seen);
            if (row_typed) want = row_want;
            pending_results.push_back(want);
        end
    end

    // Watchdog: ends the run when no handshake happens for too long.
    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
                || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == StallLimit) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_row        rows [$];
        t_req        r;
        t_res        no_want;
        logic [1:0]  pin_idx;
        logic [1:0]  trend;
        logic [31:0] clock_ms;
        int unsigned pick;
        int unsigned roll;
        int          base;

        // Quiet values on every request and register input from time zero.
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.operation  = OP_SAMPLE;
        req_ch.a_level    = 1'b0;
        req_ch.b_level    = 1'b0;
        req_ch.now_ms     = '0;
        req_ch.load_value = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        row_typed         = 1'b0;
        row_want          = '0;
        no_want           = '0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;

        // Model state after reset.
        lim_lo     = 0;
        lim_hi     = 100;
        inc_fast   = 16'd10;
        inc_slow   = 16'd1;
        window_ms  = 32'd50;
        last_ab    = 2'b00;
        half_cycle = 1'b0;
        step_stamp = 32'd0;
        count      = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests under the reset register values.
        rows.push_back(vector_row(OP_SAMPLE, 1'b0, 1'b0, 32'd0, 0, 1'b1, 0, 2'sd0));
        rows.push_back(vector_row(OP_SAMPLE, 1'b0, 1'b1, 32'd5, 0));
        // First full step has no previous step time, so it is slow.
        rows.push_back(vector_row(OP_SAMPLE, 1'b1, 1'b1, 32'd10, 0));
        rows.push_back(vector_row(OP_SAMPLE, 1'b1, 1'b0, 32'd20, 0));
        rows.push_back(vector_row(OP_SAMPLE, 1'b0, 1'b0, 32'd30, 0));
        // Reverse rotation after a long pause.
        rows.push_back(vector_row(OP_SAMPLE, 1'b1, 1'b0, 32'd40, 0));
        rows.push_back(vector_row(OP_SAMPLE, 1'b1, 1'b1, 32'd1000, 0));
        // Both pins change at once: no direction, but the parity still flips.
        rows.push_back(vector_row(OP_SAMPLE, 1'b0, 1'b0, 32'd1001, 0));
        rows.push_back(vector_row(OP_SAMPLE, 1'b1, 1'b1, 32'd1002, 0));
        // Loads at, beyond and far beyond the limits.
        rows.push_back(vector_row(OP_LOAD, 1'b0, 1'b0, 32'd1003, 100, 1'b1, 100, 2'sd0));
        rows.push_back(vector_row(OP_LOAD, 1'b1, 1'b1, 32'd1004, 101, 1'b1, 100, 2'sd0));
        rows.push_back(vector_row(OP_LOAD, 1'b0, 1'b0, 32'd1005, -1, 1'b1, 100, 2'sd0));
        rows.push_back(vector_row(OP_LOAD, 1'b0, 1'b0, 32'd1006, 0, 1'b1, 0, 2'sd0));
        rows.push_back(vector_row(OP_LOAD, 1'b0, 1'b1, 32'd1007, 32'sh7fffffff,
                                  1'b1, 0, 2'sd0));
        rows.push_back(vector_row(OP_LOAD, 1'b1, 1'b0, 32'd1008, 32'sh80000000,
                                  1'b1, 0, 2'sd0));
        // The unused operation leaves everything alone.
        rows.push_back(vector_row(OpUnused, 1'b0, 1'b0, 32'hffffffff, 32'sh7fffffff,
                                  1'b1, 0, 2'sd0));
        rows.push_back(vector_row(OP_CLEAR, 1'b1, 1'b1, 32'hffffffff, 32'sh80000000,
                                  1'b1, 0, 2'sd0));
        // Elapsed time wraps past zero; the fast step then hits the lower limit.
        rows.push_back(vector_row(OP_SAMPLE, 1'b0, 1'b1, 32'd5, 0));
        rows.push_back(vector_row(OP_SAMPLE, 1'b0, 1'b0, 32'd10, 0));
        rows.push_back(vector_row(OP_LOAD, 1'b0, 1'b0, 32'd11, 95, 1'b1, 95, 2'sd0));
        rows.push_back(vector_row(OP_SAMPLE, 1'b0, 1'b1, 32'd20, 0));
        rows.push_back(vector_row(OP_SAMPLE, 1'b1, 1'b1, 32'd30, 0));
        // Zero elapsed time since the last step falls back to the slow step.
        rows.push_back(vector_row(OP_SAMPLE, 1'b1, 1'b0, 32'd30, 0));
        rows.push_back(vector_row(OP_SAMPLE, 1'b0, 1'b0, 32'd30, 0));
        // Clearing at time zero brings back the no-previous-step state.
        rows.push_back(vector_row(OP_CLEAR, 1'b0, 1'b0, 32'd0, 0, 1'b1, 0, 2'sd0));

        foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].want);

        // Random part: the pin generator walks the Gray sequence by index.
        pin_idx  = 2'd0;
        trend    = 2'd1;
        clock_ms = 32'd100;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 82 : 0;
            recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 22 : 0;
            for (int s = 0; s < 2; s++) begin
                case (ph * 2 + s)
                    0: set_config(-500, 500, 16'd7, 16'd1, 32'd20);
                    1: set_config(32'sh80000000, 32'sh7fffffff, 16'hffff, 16'hffff,
                                  32'hffffffff);
                    2: set_config(50, -50, 16'd0, 16'd3, 32'd0);
                    3: set_config(-20, 20, 16'd5, 16'd2, 32'd8);
                    4: set_config(-int'($urandom_range(0, 1000)),
                                  int'($urandom_range(0, 1000)), 16'($urandom),
                                  16'($urandom_range(0, 20)), $urandom_range(1, 40));
                    default: set_config(32'sh80000000, 32'sh80000010, 16'h8000, 16'd0,
                                        32'd100);
                endcase
                for (int n = 0; n < ItemsPerSetting; n++) begin
                    roll = $urandom_range(0, 19);
                    if (roll == 0)
                        clock_ms = $urandom;
                    else if (roll < 4)
                        clock_ms = clock_ms;
                    else
                        clock_ms = clock_ms + $urandom_range(1, 60);
                    r.op   = OP_SAMPLE;
                    r.now  = clock_ms;
                    r.load = $urandom;
                    r.a    = 1'($urandom_range(0, 1));
                    r.b    = 1'($urandom_range(0, 1));
                    pick   = $urandom_range(0, 99);
                    if (pick < 84) begin
                        // Mostly clean rotation with an occasional reversal,
                        // some repeated samples and a few skipped states.
                        if (pick < 72) begin
                            if ($urandom_range(0, 9) == 0) trend = -trend;
                            pin_idx = pin_idx + trend;
                        end else if (pick >= 80) begin
                            pin_idx = pin_idx + 2'd2;
                        end
                        r.a = pin_idx[1];
                        r.b = pin_idx[1] ^ pin_idx[0];
                    end else if (pick < 93) begin
                        r.op = OP_LOAD;
                        if ($urandom_range(0, 2) != 0) begin
                            base   = $urandom_range(0, 1) ? lim_lo : lim_hi;
                            r.load = base + int'($urandom_range(0, 4)) - 2;
                        end
                    end else if (pick < 96) begin
                        r.op = OP_CLEAR;
                    end else if (pick < 98) begin
                        r.op = OpUnused;
                    end else begin
                        // Noise on the pins; the generator resyncs to it.
                        pin_idx = {r.a, r.a ^ r.b};
                    end
                    send_req(r, 1'b0, no_want);
                    if ($urandom_range(0, 49) == 0) wait_drained();
                end
            end
        end

        wait_drained();
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
